>>> sv/fnc_pkg.sv
// Package: constants, types and byte classifier for the FASTA nucleotide counter.
package fnc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int LEN_WIDTH   = 20;
  localparam int MAXSEQ_WIDTH = 14;
  localparam int SEQ_WIDTH   = 15;
  localparam int CFG_IDX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH = 20;
  localparam int NUM_BINS    = 5;
  localparam int BIN_WIDTH   = $clog2(NUM_BINS);

  localparam logic [LEN_WIDTH-1:0]    MAX_LEN_RESET  = LEN_WIDTH'(79999);
  localparam logic [MAXSEQ_WIDTH-1:0] MAX_SEQS_RESET = MAXSEQ_WIDTH'(10000);
  localparam logic [SEQ_WIDTH-1:0]    SEQ_SAT        = '1;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_GT = 8'h3E;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_MAX_LEN  = 1'b0,
    REG_MAX_SEQS = 1'b1
  } fnc_reg_t;

  typedef enum logic [5:0] {
    M_SKIP_FIRST = 6'b000001,
    M_LINE_START = 6'b000010,
    M_IN_LINE    = 6'b000100,
    M_LINE_DEAD  = 6'b001000,
    M_HEADER     = 6'b010000,
    M_STOPPED    = 6'b100000
  } fnc_mode_t;

  typedef enum logic [2:0] {
    CL_A    = 3'd0,
    CL_C    = 3'd1,
    CL_G    = 3'd2,
    CL_T    = 3'd3,
    CL_N    = 3'd4,
    CL_SKIP = 3'd5,
    CL_END  = 3'd6
  } fnc_class_t;

  function automatic fnc_class_t fnc_classify(input logic [7:0] b);
    logic [6:0] c;
    fnc_class_t k;
    c = b[6:0];
    unique case (c) inside
      7'h41, 7'h61: k = CL_A;
      7'h43, 7'h63: k = CL_C;
      7'h47, 7'h67: k = CL_G;
      7'h54, 7'h74: k = CL_T;
      7'h4E, 7'h6E: k = CL_N;
      7'h00, 7'h0D, 7'h0A, 7'h2A, 7'h40: k = CL_END;
      default: k = CL_SKIP;
    endcase
    return k;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] fnc_sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [OUT_WIDTH-1:0] fnc_clamp(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'({OUT_WIDTH{1'b1}})) ? '1 : w[OUT_WIDTH-1:0];
  endfunction

endpackage

>>> sv/fnc_if.sv
// Channel interfaces: text input, result output and configuration write.
interface fnc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_file;
  modport source (output valid, output text_byte, output end_of_file, input ready);
  modport sink   (input valid, input text_byte, input end_of_file, output ready);
endinterface

interface fnc_out_if;
  logic                             valid;
  logic                             ready;
  logic [fnc_pkg::OUT_WIDTH-1:0]    count_a;
  logic [fnc_pkg::OUT_WIDTH-1:0]    count_c;
  logic [fnc_pkg::OUT_WIDTH-1:0]    count_g;
  logic [fnc_pkg::OUT_WIDTH-1:0]    count_t;
  logic [fnc_pkg::OUT_WIDTH-1:0]    count_n;
  logic [fnc_pkg::OUT_WIDTH-1:0]    total_residues;
  logic [fnc_pkg::SEQ_WIDTH-1:0]    sequence_count;
  modport source (output valid, output count_a, output count_c, output count_g,
                  output count_t, output count_n, output total_residues,
                  output sequence_count, input ready);
  modport sink   (input valid, input count_a, input count_c, input count_g,
                  input count_t, input count_n, input total_residues,
                  input sequence_count, output ready);
endinterface

interface fnc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fnc_pkg::CFG_IDX_WIDTH-1:0]   index;
  logic [fnc_pkg::CFG_DATA_WIDTH-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/fasta_nucleotide_counter.sv
// Top level: FASTA nucleotide composition counter.
// The result item is registered: it becomes valid in the cycle after the end-of-file byte is accepted.
// Throughput: one byte item per cycle; input stalls only while a result waits.
// Parsing state and counters update in the accept cycle; counters are 32-bit adders.
// Reset (synchronous, rst_n low): counters and parser cleared, limits set to defaults.
// After each result the parser and counters clear; configuration is kept.
module fasta_nucleotide_counter (
  input  logic      clk,
  input  logic      rst_n,
  fnc_in_if.sink    in_ch,
  fnc_out_if.source out_ch,
  fnc_cfg_if.sink   cfg_ch
);
  import fnc_pkg::*;

  logic [LEN_WIDTH-1:0]    max_len_r;
  logic [MAXSEQ_WIDTH-1:0] max_seqs_r;

  fnc_mode_t               mode_r, mode_nxt;
  logic [LEN_WIDTH-1:0]    len_r, len_nxt;
  logic [COUNT_WIDTH-1:0]  cnt_r [NUM_BINS];
  logic [COUNT_WIDTH-1:0]  cnt_nxt [NUM_BINS];
  logic [COUNT_WIDTH-1:0]  tot_r, tot_nxt;
  logic [SEQ_WIDTH-1:0]    seq_r, seq_nxt, seq_new, seq_fin;

  logic                    out_valid_r;
  logic [OUT_WIDTH-1:0]    res_cnt_r [NUM_BINS];
  logic [OUT_WIDTH-1:0]    res_tot_r;
  logic [SEQ_WIDTH-1:0]    res_seq_r;

  logic                    in_acc;
  logic                    scan;
  fnc_class_t              cls;
  logic [BIN_WIDTH-1:0]    bin;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    tot_nxt  = tot_r;
    seq_nxt  = seq_r;
    scan     = 1'b0;
    cls      = fnc_classify(in_ch.text_byte);
    bin      = cls[BIN_WIDTH-1:0];
    seq_new  = (seq_r == SEQ_SAT) ? seq_r : seq_r + SEQ_WIDTH'(1);

    unique case (mode_r) inside
      M_SKIP_FIRST, M_LINE_DEAD, M_HEADER: begin
        if (in_ch.text_byte == CHAR_LF) mode_nxt = M_LINE_START;
      end
      M_LINE_START: begin
        if (in_ch.text_byte == CHAR_GT) begin
          if (len_r == '0) begin
            mode_nxt = M_STOPPED;
          end else begin
            seq_nxt  = seq_new;
            len_nxt  = '0;
            mode_nxt = (seq_new > SEQ_WIDTH'(max_seqs_r)) ? M_STOPPED : M_HEADER;
          end
        end else begin
          scan = 1'b1;
        end
      end
      M_IN_LINE: scan = 1'b1;
      M_STOPPED: mode_nxt = M_STOPPED;
      default:   mode_nxt = M_STOPPED;
    endcase

    if (scan) begin
      if (in_ch.text_byte == CHAR_LF) begin
        mode_nxt = M_LINE_START;
      end else if (len_r >= max_len_r || cls == CL_END) begin
        mode_nxt = M_LINE_DEAD;
      end else begin
        mode_nxt = M_IN_LINE;
        if (cls != CL_SKIP) begin
          cnt_nxt[bin] = fnc_sat_inc(cnt_r[bin]);
          tot_nxt      = fnc_sat_inc(tot_r);
          len_nxt      = len_r + LEN_WIDTH'(1);
        end
      end
    end

    seq_fin = seq_nxt;
    if (mode_nxt != M_STOPPED && len_nxt != '0 && seq_nxt != SEQ_SAT)
      seq_fin = seq_nxt + SEQ_WIDTH'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= MAX_LEN_RESET;
      max_seqs_r <= MAX_SEQS_RESET;
    end else if (cfg_ch.valid) begin
      unique case (fnc_reg_t'(cfg_ch.index))
        REG_MAX_LEN:  max_len_r  <= cfg_ch.data[LEN_WIDTH-1:0];
        REG_MAX_SEQS: max_seqs_r <= cfg_ch.data[MAXSEQ_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_SKIP_FIRST;
      len_r  <= '0;
      tot_r  <= '0;
      seq_r  <= '0;
      for (int i = 0; i < NUM_BINS; i++) cnt_r[i] <= '0;
    end else if (in_acc) begin
      if (in_ch.end_of_file) begin
        mode_r <= M_SKIP_FIRST;
        len_r  <= '0;
        tot_r  <= '0;
        seq_r  <= '0;
        for (int i = 0; i < NUM_BINS; i++) cnt_r[i] <= '0;
      end else begin
        mode_r <= mode_nxt;
        len_r  <= len_nxt;
        tot_r  <= tot_nxt;
        seq_r  <= seq_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_ch.end_of_file) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.end_of_file) begin
      for (int i = 0; i < NUM_BINS; i++) res_cnt_r[i] <= fnc_clamp(cnt_nxt[i]);
      res_tot_r <= fnc_clamp(tot_nxt);
      res_seq_r <= seq_fin;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.count_a        = res_cnt_r[0];
  assign out_ch.count_c        = res_cnt_r[1];
  assign out_ch.count_g        = res_cnt_r[2];
  assign out_ch.count_t        = res_cnt_r[3];
  assign out_ch.count_n        = res_cnt_r[4];
  assign out_ch.total_residues = res_tot_r;
  assign out_ch.sequence_count = res_seq_r;

endmodule

>>> bench/fnc_checker.sv
// Checker: watches the text, result and register channels, predicts the counts and compares.
`timescale 1ns / 100ps
module fnc_checker (
  input  logic clk,
  input  logic rst_n,
  fnc_in_if    in_ch,
  fnc_out_if   out_ch,
  fnc_cfg_if   cfg_ch,
  output int   pending,
  output int   fails
);
  import fnc_pkg::*;

  typedef struct {
    logic [OUT_WIDTH-1:0] base [NUM_BINS];
    logic [OUT_WIDTH-1:0] total;
    logic [SEQ_WIDTH-1:0] seqs;
  } tally_t;

  tally_t tally_q [$];
  tally_t want, got;

  logic [LEN_WIDTH-1:0]    len_limit;
  logic [MAXSEQ_WIDTH-1:0] seq_limit;
  fnc_mode_t               mode;
  logic [LEN_WIDTH-1:0]    run_len;
  logic [COUNT_WIDTH-1:0]  bin_cnt [NUM_BINS];
  logic [COUNT_WIDTH-1:0]  residues;
  logic [SEQ_WIDTH-1:0]    seqs_done;
  int                      err_count = 0;

  string bin_names [NUM_BINS] = '{"count_a", "count_c", "count_g", "count_t", "count_n"};

  // -1: end of useful part, 0: ignored, 1..5: residue bin + 1
  function automatic int residue_bin(input logic [7:0] b);
    logic [6:0] c;
    logic [7:0] lc;
    c = b[6:0];
    lc = {1'b0, c | 7'h20};
    if (c == 7'h00 || c == 7'h0D || {1'b0, c} == CHAR_LF || c == "*" || c == "@")
      return -1;
    case (lc)
      "a": return 1;
      "c": return 2;
      "g": return 3;
      "t": return 4;
      "n": return 5;
      default: return 0;
    endcase
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
    return ((v >> OUT_WIDTH) != 0) ? '1 : OUT_WIDTH'(v);
  endfunction

  function void clear_counts();
    mode = M_SKIP_FIRST;
    run_len = '0;
    foreach (bin_cnt[i]) bin_cnt[i] = '0;
    residues = '0;
    seqs_done = '0;
  endfunction

  function void scan(input logic [7:0] b);
    int k;
    k = residue_bin(b);
    if (b == CHAR_LF) begin
      mode = M_LINE_START;
    end else if (run_len >= len_limit || k < 0) begin
      mode = M_LINE_DEAD;
    end else begin
      mode = M_IN_LINE;
      if (k > 0) begin
        bin_cnt[k-1] = bump(bin_cnt[k-1]);
        residues = bump(residues);
        run_len = run_len + LEN_WIDTH'(1);
      end
    end
  endfunction

  function fnc_mode_t close_sequence();
    if (run_len == 0) return M_STOPPED;
    if (seqs_done != SEQ_SAT) seqs_done = seqs_done + SEQ_WIDTH'(1);
    run_len = '0;
    if (seqs_done > seq_limit) return M_STOPPED;
    return M_HEADER;
  endfunction

  function void take_byte(input logic [7:0] b, input logic eof);
    tally_t t;
    case (mode) inside
      M_SKIP_FIRST, M_LINE_DEAD, M_HEADER: begin
        if (b == CHAR_LF) mode = M_LINE_START;
      end
      M_LINE_START: begin
        if (b == CHAR_GT) mode = close_sequence();
        else scan(b);
      end
      M_IN_LINE: scan(b);
      default: mode = M_STOPPED;
    endcase
    if (eof) begin
      if (mode != M_STOPPED && run_len != 0 && seqs_done != SEQ_SAT)
        seqs_done = seqs_done + SEQ_WIDTH'(1);
      foreach (bin_cnt[i]) t.base[i] = to_out(bin_cnt[i]);
      t.total = to_out(residues);
      t.seqs = seqs_done;
      tally_q.push_back(t);
      clear_counts();
    end
  endfunction

  function void match(input string field, input logic [OUT_WIDTH-1:0] exp_v,
                      input logic [OUT_WIDTH-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      len_limit = MAX_LEN_RESET;
      seq_limit = MAX_SEQS_RESET;
      clear_counts();
      tally_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (fnc_reg_t'(cfg_ch.index))
          REG_MAX_LEN:  len_limit = cfg_ch.data[LEN_WIDTH-1:0];
          REG_MAX_SEQS: seq_limit = cfg_ch.data[MAXSEQ_WIDTH-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tally_q.size() == 0) begin
          $error("result item with no expected result pending");
          err_count++;
        end else begin
          want = tally_q.pop_front();
          got.base[0] = out_ch.count_a;
          got.base[1] = out_ch.count_c;
          got.base[2] = out_ch.count_g;
          got.base[3] = out_ch.count_t;
          got.base[4] = out_ch.count_n;
          got.total = out_ch.total_residues;
          got.seqs = out_ch.sequence_count;
          foreach (bin_names[i]) match(bin_names[i], want.base[i], got.base[i]);
          match("total_residues", want.total, got.total);
          match("sequence_count", OUT_WIDTH'(want.seqs), OUT_WIDTH'(got.seqs));
        end
      end
      if (in_ch.valid && in_ch.ready) take_byte(in_ch.text_byte, in_ch.end_of_file);
    end
    pending <= tally_q.size();
    fails <= err_count;
  end

endmodule

>>> bench/tb_fasta_nucleotide_counter.sv
// Testbench top: drives FASTA text files and register writes, reports the verdict.
`timescale 1ns / 100ps
module tb_fasta_nucleotide_counter;
  import fnc_pkg::*;

  logic clk;
  logic rst_n;

  fnc_in_if  in_ch ();
  fnc_out_if out_ch ();
  fnc_cfg_if cfg_ch ();

  int pending;
  int fails;
  int tx_idle_pct = 21;
  int rx_idle_pct = 62;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int sent = 0;

  logic [7:0] text_q [$];

  fasta_nucleotide_counter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  fnc_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .pending (pending),
    .fails   (fails)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_fasta_nucleotide_counter failed");
    $finish;
  end

  // result receiver; long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      out_ch.ready <= 1'b0;
      hold_done <= hold_done + 1;
      hold_left <= 400;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eof);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.end_of_file <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input fnc_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_residue();
    string      letters = "ACGTNacgtn";
    logic [7:0] stops [5] = '{8'h00, 8'h0D, "*", "@", 8'h8A};
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 80) begin
      b = letters[$urandom_range(9)];
      if ($urandom_range(9) == 0) b[7] = 1'b1;
    end else if (r < 88) begin
      b = stops[$urandom_range(4)];
    end else begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  function automatic void add_header();
    text_q.push_back(CHAR_GT);
    repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(33, 126)));
    text_q.push_back(CHAR_LF);
  endfunction

  function automatic void build_file();
    int nseq;
    int nlines;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    add_header();
    nseq = $urandom_range(1, 4);
    for (int s = 0; s < nseq; s++) begin
      if (s > 0) add_header();
      nlines = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3);
      for (int l = 0; l < nlines; l++) begin
        repeat ($urandom_range(0, 8)) text_q.push_back(pick_residue());
        if ($urandom_range(5) == 0) text_q.push_back(8'h0D);
        text_q.push_back(CHAR_LF);
      end
    end
    if ($urandom_range(3) == 0 && text_q.size() > 1) void'(text_q.pop_back());
  endfunction

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.end_of_file = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAX_LEN;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // masked bytes, header test on raw byte, line terminators, two sequences
    text_q = '{"h", CHAR_LF, "A", "c", "G", "t", "N", "n", 8'hC7, 8'h8A, "a", CHAR_LF,
               8'hBE, "T", "@", "g", CHAR_LF, CHAR_GT, CHAR_LF, 8'hFF, "c"};
    send_text();
    // empty sequence stops counting
    text_q = '{CHAR_LF, CHAR_GT, CHAR_LF, CHAR_GT, "A"};
    send_text();
    // end of file on the first byte
    text_q = '{8'h00};
    send_text();
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin
          write_reg(REG_MAX_LEN, 20'd1);
          write_reg(REG_MAX_SEQS, 20'd1);
        end
        2: begin
          write_reg(REG_MAX_LEN, 20'd1048575);
          write_reg(REG_MAX_SEQS, 20'd16383);
        end
        3: begin
          write_reg(REG_MAX_LEN, 20'($urandom_range(1, 6)));
          write_reg(REG_MAX_SEQS, 20'($urandom_range(1, 3)));
        end
        4: begin
          write_reg(REG_MAX_LEN, 20'($urandom_range(1, 40)));
          write_reg(REG_MAX_SEQS, 20'($urandom_range(1, 16383)));
        end
        5: begin
          write_reg(REG_MAX_LEN, 20'($urandom_range(1, 1048575)));
          write_reg(REG_MAX_SEQS, 20'($urandom_range(1, 5)));
        end
        default: ;
      endcase
      if (p < 2) begin
        tx_idle_pct = 21;
        rx_idle_pct = 62;
      end else if (p < 4) begin
        tx_idle_pct = 62;
        rx_idle_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 2) begin
        // receiver stalls while short files keep coming
        hold_reqs <= hold_reqs + 1;
        repeat (6) begin
          text_q = '{CHAR_LF, "A", "c", CHAR_GT, CHAR_LF, "G"};
          send_text();
        end
        settle();
      end
      while (sent < 27 + (p + 1) * 320) begin
        build_file();
        send_text();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (fails == 0)
      $display("tb_fasta_nucleotide_counter passed");
    else
      $display("tb_fasta_nucleotide_counter failed");
    $finish;
  end

endmodule
